// File: src/cia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types, operation codes and widths for the complex integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

   localparam int WIDTH_DEF = 32;
   localparam int FIELD_W   = 32;
   localparam int FUNC_W    = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   // operation codes
   localparam logic [FUNC_W-1:0] OP_CADD = 3'd0;
   localparam logic [FUNC_W-1:0] OP_CSUB = 3'd1;
   localparam logic [FUNC_W-1:0] OP_CMUL = 3'd2;
   localparam logic [FUNC_W-1:0] OP_CDIV = 3'd3;
   localparam logic [FUNC_W-1:0] OP_SADD = 3'd4;
   localparam logic [FUNC_W-1:0] OP_SSUB = 3'd5;
   localparam logic [FUNC_W-1:0] OP_SMUL = 3'd6;
   localparam logic [FUNC_W-1:0] OP_SDIV = 3'd7;

   // decoded operation class from the front part
   typedef struct packed {
      logic is_add;   // plain add/sub path
      logic is_sub;   // subtract
      logic is_mul;   // multiply path
      logic is_div;   // divide path
      logic is_cplx;  // complex (vs scalar) form
   } op_class_type;

endpackage

// File: src/cia_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_front
// Accepts items, wraps operands to WIDTH bits, classifies the operation and
// buffers items in a short queue toward the back part.
// ----------------------------------------------------------------------------
module cia_front #(
   parameter int WIDTH = cia_pkg::WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [cia_pkg::FUNC_W-1:0]  in_func,
   input  logic [cia_pkg::FIELD_W-1:0] in_a_re,
   input  logic [cia_pkg::FIELD_W-1:0] in_a_im,
   input  logic [cia_pkg::FIELD_W-1:0] in_b_re,
   input  logic [cia_pkg::FIELD_W-1:0] in_b_im,
   output logic                        q_valid,
   input  logic                        q_ready,
   output cia_pkg::op_class_type       q_cls,
   output logic signed [WIDTH-1:0]     q_a,
   output logic signed [WIDTH-1:0]     q_b,
   output logic signed [WIDTH-1:0]     q_c,
   output logic signed [WIDTH-1:0]     q_d
);
   localparam int DEPTH = cia_pkg::QUEUE_DEPTH_DEF;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int EW = 5 + 4 * WIDTH;

   // sign-extend or wrap a 32-bit field to WIDTH bits
   function automatic logic [WIDTH-1:0] fit(input logic [cia_pkg::FIELD_W-1:0] v);
      logic [WIDTH+cia_pkg::FIELD_W-1:0] x;
      x = {{WIDTH{v[cia_pkg::FIELD_W-1]}}, v};
      return x[WIDTH-1:0];
   endfunction

   // classification
   cia_pkg::op_class_type cls;
   always_comb begin
      cls = '0;
      case (in_func)
         cia_pkg::OP_CADD: begin cls.is_add = 1'b1; cls.is_cplx = 1'b1; end
         cia_pkg::OP_CSUB: begin cls.is_add = 1'b1; cls.is_sub = 1'b1; cls.is_cplx = 1'b1; end
         cia_pkg::OP_CMUL: begin cls.is_mul = 1'b1; cls.is_cplx = 1'b1; end
         cia_pkg::OP_CDIV: begin cls.is_div = 1'b1; cls.is_cplx = 1'b1; end
         cia_pkg::OP_SADD: cls.is_add = 1'b1;
         cia_pkg::OP_SSUB: begin cls.is_add = 1'b1; cls.is_sub = 1'b1; end
         cia_pkg::OP_SMUL: cls.is_mul = 1'b1;
         default:          cls.is_div = 1'b1;
      endcase
   end

   // queue storage
   logic [EW-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          push, pop;

   assign in_ready = (count_ff != (AW+1)'(DEPTH));
   assign q_valid  = (count_ff != '0);
   assign push     = in_valid && in_ready;
   assign pop      = q_valid && q_ready;

   function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? nxt(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? nxt(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   // pointer and count registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry write
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= {cls, fit(in_a_re), fit(in_a_im), fit(in_b_re), fit(in_b_im)};
      end
   end

   // head of queue
   assign {q_cls, q_a, q_b, q_c, q_d} = mem_ff[rd_ptr_ff];
endmodule

// File: src/cia_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cia_back
// Pipelined execution: products, combine, then a radix-2 restoring divider
// with one stage per quotient bit, then an output register.
// ----------------------------------------------------------------------------
module cia_back #(
   parameter int WIDTH = cia_pkg::WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  cia_pkg::op_class_type       q_cls,
   input  logic signed [WIDTH-1:0]     q_a,
   input  logic signed [WIDTH-1:0]     q_b,
   input  logic signed [WIDTH-1:0]     q_c,
   input  logic signed [WIDTH-1:0]     q_d,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [cia_pkg::FIELD_W-1:0] out_re,
   output logic [cia_pkg::FIELD_W-1:0] out_im,
   output logic                        out_dz
);
   localparam int NS = WIDTH + 3;   // stages: product, combine, WIDTH div, finish

   // the whole pipe advances together; output register drains it
   logic adv;
   logic vld_ff [NS];
   assign adv     = !vld_ff[NS-1] || out_ready;
   assign q_ready = adv;

   // stage 0: products (one WIDTH x WIDTH multiply each, wrapped)
   cia_pkg::op_class_type s0_cls_ff;
   logic [WIDTH-1:0] s0_a_ff, s0_b_ff, s0_c_ff;
   logic [WIDTH-1:0] p_ac_ff, p_bd_ff, p_ad_ff, p_bc_ff, p_cc_ff, p_dd_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         s0_cls_ff <= q_cls;
         s0_a_ff   <= q_a;
         s0_b_ff   <= q_b;
         s0_c_ff   <= q_c;
         p_ac_ff   <= q_a * q_c;
         p_bd_ff   <= q_b * q_d;
         p_ad_ff   <= q_a * q_d;
         p_bc_ff   <= q_b * q_c;
         p_cc_ff   <= q_c * q_c;
         p_dd_ff   <= q_d * q_d;
      end
   end

   // stage 1: combine, pick numerators and divisor, take magnitudes
   logic [WIDTH-1:0] c_re, c_im, n_re, n_im, den;
   always_comb begin
      c_re = '0; c_im = '0; n_re = '0; n_im = '0; den = '0;
      if (s0_cls_ff.is_add) begin
         c_re = s0_cls_ff.is_sub ? s0_a_ff - s0_c_ff : s0_a_ff + s0_c_ff;
      end else if (s0_cls_ff.is_mul) begin
         c_re = s0_cls_ff.is_cplx ? p_ac_ff - p_bd_ff : p_ac_ff;
         c_im = s0_cls_ff.is_cplx ? p_ad_ff + p_bc_ff : p_bc_ff;
      end
      if (s0_cls_ff.is_cplx) begin
         n_re = p_ac_ff + p_bd_ff;
         n_im = p_bc_ff - p_ad_ff;
         den  = p_cc_ff + p_dd_ff;
      end else begin
         n_re = s0_a_ff;
         n_im = s0_b_ff;
         den  = s0_c_ff;
      end
   end

   // complex add/sub need b +/- d: d kept via a separate register
   logic [WIDTH-1:0] s0_d_ff;
   always_ff @(posedge clock) if (adv) s0_d_ff <= q_d;
   logic [WIDTH-1:0] add_im;
   assign add_im = s0_cls_ff.is_cplx ? (s0_cls_ff.is_sub ? s0_b_ff - s0_d_ff
                                                         : s0_b_ff + s0_d_ff)
                                     : s0_b_ff;

   // divider stage state: remainder, quotient, divisor magnitude, signs
   typedef struct packed {
      logic             is_div;
      logic             dz;
      logic             neg_re;
      logic             neg_im;
      logic [WIDTH-1:0] dv;
      logic [WIDTH-1:0] r_re;
      logic [WIDTH-1:0] q_re;   // holds shifting dividend then quotient
      logic [WIDTH-1:0] r_im;
      logic [WIDTH-1:0] q_im;
      logic [WIDTH-1:0] o_re;   // non-divide result
      logic [WIDTH-1:0] o_im;
   } dstage_type;

   dstage_type st_ff [WIDTH+1];
   dstage_type st1;
   always_comb begin
      st1        = '0;
      st1.is_div = s0_cls_ff.is_div;
      st1.dz     = s0_cls_ff.is_div && (den == '0);
      st1.neg_re = n_re[WIDTH-1] ^ den[WIDTH-1];
      st1.neg_im = n_im[WIDTH-1] ^ den[WIDTH-1];
      st1.dv     = den[WIDTH-1] ? -den : den;
      st1.q_re   = n_re[WIDTH-1] ? -n_re : n_re;
      st1.q_im   = n_im[WIDTH-1] ? -n_im : n_im;
      st1.o_re   = c_re;
      st1.o_im   = s0_cls_ff.is_add ? add_im : c_im;
   end

   // one restoring step per stage, both parts in parallel
   function automatic logic [2*WIDTH-1:0] dstep(input logic [WIDTH-1:0] r,
         input logic [WIDTH-1:0] q, input logic [WIDTH-1:0] dv);
      logic [WIDTH:0] t;
      logic [WIDTH:0] s;
      t = {r, q[WIDTH-1]};
      s = t - {1'b0, dv};
      if (!s[WIDTH]) return {s[WIDTH-1:0], q[WIDTH-2:0], 1'b1};
      return {t[WIDTH-1:0], q[WIDTH-2:0], 1'b0};
   endfunction

   dstage_type nx [WIDTH];
   always_comb begin
      for (int g = 0; g < WIDTH; g++) begin
         nx[g] = st_ff[g];
         {nx[g].r_re, nx[g].q_re} = dstep(st_ff[g].r_re, st_ff[g].q_re, st_ff[g].dv);
         {nx[g].r_im, nx[g].q_im} = dstep(st_ff[g].r_im, st_ff[g].q_im, st_ff[g].dv);
      end
   end

   // divider stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0] <= st1;
         for (int g = 0; g < WIDTH; g++) st_ff[g+1] <= nx[g];
      end
   end

   // finish: sign fix and select, into the output register
   dstage_type fin;
   logic [WIDTH-1:0] f_re, f_im;
   assign fin = st_ff[WIDTH];
   always_comb begin
      if (!fin.is_div) begin
         f_re = fin.o_re;
         f_im = fin.o_im;
      end else if (fin.dz) begin
         f_re = '0;
         f_im = '0;
      end else begin
         f_re = fin.neg_re ? -fin.q_re : fin.q_re;
         f_im = fin.neg_im ? -fin.q_im : fin.q_im;
      end
   end

   logic [WIDTH+cia_pkg::FIELD_W-1:0] x_re, x_im;
   assign x_re = {{cia_pkg::FIELD_W{f_re[WIDTH-1]}}, f_re};
   assign x_im = {{cia_pkg::FIELD_W{f_im[WIDTH-1]}}, f_im};
   always_ff @(posedge clock) begin
      if (adv) begin
         out_re <= x_re[cia_pkg::FIELD_W-1:0];
         out_im <= x_im[cia_pkg::FIELD_W-1:0];
         out_dz <= fin.is_div && fin.dz;
      end
   end

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= q_valid;
         for (int i = 1; i < NS; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end
   assign out_valid = vld_ff[NS-1];
endmodule

// File: src/complex_integer_alu_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_integer_alu_top
// Complex integer ALU: add, subtract, multiply, divide, complex and scalar.
// ----------------------------------------------------------------------------
// channel | dir | signals
// req     | in  | tvalid tready tdata{b_im,b_re,a_im,a_re} tuser{func}
// rsp     | out | tvalid tready tdata{div_zero,res_im,res_re}
//
// one item per cycle sustained while rsp_tready is held high; a result passes
// the queue entry written at the request transfer, then the product stage,
// combine stage, WIDTH divider steps and output register.
// the front queue takes items while the back pipe is stalled, until it is full.
// reset is synchronous and clears queue pointers and the valid pipe.
// ----------------------------------------------------------------------------
module complex_integer_alu_top #(
   parameter int WIDTH = cia_pkg::WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // a_re, a_im, b_re, b_im
   input  logic [2:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [71:0]  rsp_tdata    // res_re, res_im, div_zero, zero pad
);
   cia_pkg::op_class_type q_cls;
   logic q_valid, q_ready, dz;
   logic signed [WIDTH-1:0] q_a, q_b, q_c, q_d;
   logic [31:0] re, im;

   // front: accept and classify
   cia_front #(.WIDTH(WIDTH)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_func(req_tuser),
      .in_a_re(req_tdata[31:0]), .in_a_im(req_tdata[63:32]),
      .in_b_re(req_tdata[95:64]), .in_b_im(req_tdata[127:96]),
      .q_valid(q_valid), .q_ready(q_ready), .q_cls(q_cls),
      .q_a(q_a), .q_b(q_b), .q_c(q_c), .q_d(q_d)
   );

   // back: execute
   cia_back #(.WIDTH(WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_ready(q_ready), .q_cls(q_cls),
      .q_a(q_a), .q_b(q_b), .q_c(q_c), .q_d(q_d),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_re(re), .out_im(im), .out_dz(dz)
   );

   assign rsp_tdata = {7'd0, dz, im, re};
endmodule
